// ===== hdl/fpla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fpla_pkg;

  localparam int unsigned PAGE_OUT_W = 12;
  localparam int unsigned COUNT_OUT_W = 13;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BADPAGE = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic step;
  } chain_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/free_page_list_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// LIFO page allocator over a next-link memory; page 0 is the header. Pulse start
// while busy is low; the result appears on done_o for one cycle and cannot be
// stalled. A free is answered straight from idle, an allocate after a pop state
// (memory read of the head link). An allocate on an empty list first chains the
// new pages n..2n-1 through the shared chain counter, one memory write per cycle;
// if 2n exceeds MAX_PAGES it returns STAT_FULL instead. After reset the block is
// busy while the same counter writes the initial chain into the memory.
module free_page_list_allocator_top import fpla_pkg::*; #(
  parameter int unsigned MAX_PAGES     = 4096,
  parameter int unsigned INITIAL_PAGES = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   action_i,
  input  wire logic [PAGE_OUT_W-1:0]  page_num_i,
  output logic                        done_o,
  output logic [PAGE_OUT_W-1:0]       page_out_o,
  output logic [1:0]                  status_o,
  output logic [COUNT_OUT_W-1:0]      page_count_o
);

  localparam int unsigned DEPTH  = (MAX_PAGES > INITIAL_PAGES) ? MAX_PAGES : INITIAL_PAGES;
  localparam int unsigned PAGE_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned PX     = (PAGE_W > PAGE_OUT_W) ? PAGE_W : PAGE_OUT_W;
  localparam int unsigned CX     = (CNT_W + 1 > COUNT_OUT_W) ? CNT_W + 1 : COUNT_OUT_W;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_GROW = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PAGE_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              done_q, done_d;
  logic [PAGE_W-1:0] got_q, got_d;
  status_e           status_q, status_d;
  logic [CNT_W:0]    count_q, count_d;

  logic              accept;
  logic [CNT_W:0]    grow_top;
  logic              grow_full;
  logic [PAGE_W-1:0] page_idx;
  logic              page_bad;

  logic              ram_we, ram_re;
  logic [PAGE_W-1:0] ram_waddr, ram_wdata, ram_rdata;

  chain_ctl_t        chain_ctl;
  logic [PAGE_W-1:0] chain_base, chain_last, chain_idx, chain_link;
  logic              chain_end;

  logic [PX-1:0]     got_ext;
  logic [CX-1:0]     count_ext;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign grow_top  = {total_q, 1'b0};
  assign grow_full = (grow_top > (CNT_W + 1)'(MAX_PAGES));
  assign page_idx  = PAGE_W'(page_num_i);
  assign page_bad  = (page_num_i == '0) ||
                     (CX'(page_num_i) >= CX'(total_q));

  assign chain_base = PAGE_W'(total_q);
  assign chain_last = PAGE_W'(grow_top - (CNT_W + 1)'(1));

  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    total_d        = total_q;
    done_d         = 1'b0;
    got_d          = got_q;
    status_d       = status_q;
    count_d        = count_q;
    chain_ctl      = '0;
    ram_we         = 1'b0;
    ram_waddr      = chain_idx;
    ram_wdata      = chain_link;
    ram_re         = 1'b0;

    unique case (state_q)
      S_INIT: begin
        ram_we         = 1'b1;
        chain_ctl.step = 1'b1;
        if (chain_end) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_FREE) begin
            done_d   = 1'b1;
            got_d    = '0;
            count_d  = (CNT_W + 1)'(total_q);
            if (page_bad) begin
              status_d = STAT_BADPAGE;
            end else begin
              status_d  = STAT_OK;
              ram_we    = 1'b1;
              ram_waddr = page_idx;
              ram_wdata = head_q;
              head_d    = page_idx;
            end
          end else if (head_q != '0) begin
            ram_re  = 1'b1;
            state_d = S_POP;
          end else if (grow_full) begin
            done_d   = 1'b1;
            got_d    = '0;
            status_d = STAT_FULL;
            count_d  = (CNT_W + 1)'(total_q);
          end else begin
            chain_ctl.load = 1'b1;
            state_d        = S_GROW;
          end
        end
      end
      S_POP: begin
        done_d   = 1'b1;
        got_d    = head_q;
        status_d = STAT_OK;
        count_d  = (CNT_W + 1)'(total_q);
        head_d   = ram_rdata;
        state_d  = S_IDLE;
      end
      S_GROW: begin
        ram_we         = 1'b1;
        chain_ctl.step = 1'b1;
        if (chain_end) begin
          // new head is top-1; it is handed out at once, its link is top-2
          done_d   = 1'b1;
          got_d    = chain_idx;
          status_d = STAT_OK;
          count_d  = grow_top;
          total_d  = CNT_W'(grow_top);
          head_d   = chain_link;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      head_q  <= PAGE_W'(INITIAL_PAGES - 1);
      total_q <= CNT_W'(INITIAL_PAGES);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    got_q    <= got_d;
    status_q <= status_d;
    count_q  <= count_d;
  end

  fpla_chain #(
    .PAGE_W    (PAGE_W),
    .INIT_LAST (INITIAL_PAGES - 1)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (chain_ctl),
    .base_i   (chain_base),
    .last_i   (chain_last),
    .idx_o    (chain_idx),
    .link_o   (chain_link),
    .at_end_o (chain_end)
  );

  fpla_link_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (PAGE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign got_ext   = PX'(got_q);
  assign count_ext = CX'(count_q);

  assign done_o       = done_q;
  assign page_out_o   = got_ext[PAGE_OUT_W-1:0];
  assign status_o     = status_q;
  assign page_count_o = count_ext[COUNT_OUT_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/fpla_link_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fpla_link_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [ADDR_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [ADDR_W-1:0] rdata_o
);

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fpla_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Walks base..last one entry per step cycle, link = idx-1 (0 at base).
module fpla_chain import fpla_pkg::*; #(
  parameter int unsigned PAGE_W    = 12,
  parameter int unsigned INIT_LAST = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire chain_ctl_t        ctl_i,
  input  wire logic [PAGE_W-1:0] base_i,
  input  wire logic [PAGE_W-1:0] last_i,
  output logic      [PAGE_W-1:0] idx_o,
  output logic      [PAGE_W-1:0] link_o,
  output logic                   at_end_o
);

  logic [PAGE_W-1:0] idx_q, idx_d;
  logic [PAGE_W-1:0] base_q, base_d;
  logic [PAGE_W-1:0] last_q, last_d;

  always_comb begin
    idx_d  = idx_q;
    base_d = base_q;
    last_d = last_q;
    if (ctl_i.load) begin
      idx_d  = base_i;
      base_d = base_i;
      last_d = last_i;
    end else if (ctl_i.step) begin
      idx_d = idx_q + PAGE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      base_q <= '0;
      last_q <= PAGE_W'(INIT_LAST);
    end else begin
      idx_q  <= idx_d;
      base_q <= base_d;
      last_q <= last_d;
    end
  end

  assign idx_o    = idx_q;
  assign link_o   = (idx_q == base_q) ? '0 : idx_q - PAGE_W'(1);
  assign at_end_o = (idx_q == last_q);

endmodule

`default_nettype wire

// ===== bench/free_page_list_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module free_page_list_allocator_top_tb import fpla_pkg::*;;

  localparam int unsigned MAX_PAGES     = 4096;
  localparam int unsigned INITIAL_PAGES = 16;
  localparam int QUIET_LIMIT = 20000;
  localparam int MAX_REPORTS = 100;
  localparam int MAX_GAP     = 40;
  localparam int CAP_ITEMS   = 100;

  typedef struct {
    logic [PAGE_OUT_W-1:0]  page;
    status_e                status;
    logic [COUNT_OUT_W-1:0] count;
  } page_result_t;

  logic                   clk_i;
  logic                   rst_ni     = 1'b0;
  logic                   start      = 1'b0;
  logic                   busy;
  logic                   action_i   = ACT_ALLOC;
  logic [PAGE_OUT_W-1:0]  page_num_i = '0;
  logic                   done_o;
  logic [PAGE_OUT_W-1:0]  page_out_o;
  logic [1:0]             status_o;
  logic [COUNT_OUT_W-1:0] page_count_o;

  // shadow of the free list
  logic [PAGE_OUT_W-1:0] link_mem [MAX_PAGES];
  logic [PAGE_OUT_W-1:0] list_head;
  int unsigned           pages_in_use;

  page_result_t          expected_results [$];
  logic [PAGE_OUT_W-1:0] held_pages [$];
  logic [PAGE_OUT_W-1:0] last_freed = '0;
  int                    mismatch_count = 0;
  int                    sender_idle_pct = 0;
  int                    quiet_cycles = 0;

  free_page_list_allocator_top #(
    .MAX_PAGES    (MAX_PAGES),
    .INITIAL_PAGES(INITIAL_PAGES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .page_num_i  (page_num_i),
    .done_o      (done_o),
    .page_out_o  (page_out_o),
    .status_o    (status_o),
    .page_count_o(page_count_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic bit grow_free_list();
    int unsigned n;
    int unsigned top;
    n   = pages_in_use;
    top = 2 * n;
    if (n == 0 || top > MAX_PAGES) begin
      return 1'b0;
    end
    link_mem[n] = '0;
    for (int unsigned i = n + 1; i < top; i++) begin
      link_mem[i] = PAGE_OUT_W'(i - 1);
    end
    list_head    = PAGE_OUT_W'(top - 1);
    pages_in_use = top;
    return 1'b1;
  endfunction

  function automatic page_result_t apply_page_request(input logic act,
                                                      input logic [PAGE_OUT_W-1:0] pg);
    page_result_t r;
    bit           have_page;
    r.page    = '0;
    r.status  = STAT_OK;
    have_page = 1'b1;
    if (act == ACT_ALLOC) begin
      if (list_head == '0) begin
        have_page = grow_free_list();
      end
      if (!have_page) begin
        r.status = STAT_FULL;
      end else begin
        r.page    = list_head;
        list_head = link_mem[r.page];
      end
    end else if (pg == '0 || int'(pg) >= int'(pages_in_use)) begin
      r.status = STAT_BADPAGE;
    end else begin
      link_mem[pg] = list_head;
      list_head    = pg;
    end
    r.count = COUNT_OUT_W'(pages_in_use);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", field, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  task automatic send_page_request(input logic act, input logic [PAGE_OUT_W-1:0] pg,
                                   output page_result_t res);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= act;
    page_num_i <= pg;
    do @(posedge clk_i); while (busy);
    res = apply_page_request(act, pg);
    expected_results.push_back(res);
    if (res.status == STAT_OK) begin
      if (act == ACT_ALLOC) begin
        held_pages.push_back(res.page);
      end else begin
        last_freed = pg;
        for (int k = 0; k < held_pages.size(); k++) begin
          if (held_pages[k] == pg) begin
            held_pages.delete(k);
            break;
          end
        end
      end
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    page_result_t r;
    sender_idle_pct = 0;
    send_page_request(ACT_FREE, '0, r);
    send_page_request(ACT_FREE, '1, r);
    send_page_request(ACT_FREE, PAGE_OUT_W'(INITIAL_PAGES), r);
    // drain the initial list, last one forces a growth step
    repeat (INITIAL_PAGES) send_page_request(ACT_ALLOC, PAGE_OUT_W'($urandom), r);
    send_page_request(ACT_FREE, PAGE_OUT_W'(2 * INITIAL_PAGES - 1), r);
    send_page_request(ACT_FREE, PAGE_OUT_W'(1), r);
    send_page_request(ACT_FREE, PAGE_OUT_W'(1), r);
    repeat (3) send_page_request(ACT_ALLOC, '1, r);
  endtask

  task automatic test_mixed_traffic(input int idle_pct, input int n_items);
    page_result_t r;
    int           pick;
    int           sel;
    sender_idle_pct = idle_pct;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_page_request(ACT_ALLOC, PAGE_OUT_W'($urandom), r);
      end else if (pick < 85 && held_pages.size() > 0) begin
        sel = $urandom_range(held_pages.size() - 1);
        send_page_request(ACT_FREE, held_pages[sel], r);
      end else if (pick < 90) begin
        send_page_request(ACT_FREE, last_freed, r);
      end else if (pick < 93) begin
        send_page_request(ACT_FREE, '0, r);
      end else if (pick < 96) begin
        send_page_request(ACT_FREE, PAGE_OUT_W'(pages_in_use), r);
      end else begin
        send_page_request(1'($urandom_range(1)), PAGE_OUT_W'($urandom), r);
      end
    end
  endtask

  task automatic test_capacity_exhaustion();
    page_result_t r;
    int           full_hits;
    int           guard;
    sender_idle_pct = 0;
    full_hits       = 0;
    guard           = 0;
    while (full_hits < 2 && guard < CAP_ITEMS) begin
      send_page_request(ACT_ALLOC, PAGE_OUT_W'($urandom), r);
      if (r.status == STAT_FULL) begin
        full_hits++;
      end
      guard++;
    end
  endtask

  initial begin
    page_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, page_out", int'(page_out_o), 0);
        end else begin
          want = expected_results.pop_front();
          if (page_out_o !== want.page) begin
            report_mismatch("page_out", int'(page_out_o), int'(want.page));
          end
          if (status_o !== want.status) begin
            report_mismatch("status", int'(status_o), int'(want.status));
          end
          if (page_count_o !== want.count) begin
            report_mismatch("page_count", int'(page_count_o), int'(want.count));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < MAX_PAGES; i++) begin
      link_mem[i] = (i >= 1 && i < INITIAL_PAGES) ? PAGE_OUT_W'(i - 1) : '0;
    end
    list_head    = PAGE_OUT_W'(INITIAL_PAGES - 1);
    pages_in_use = INITIAL_PAGES;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_mixed_traffic(0, 200);
    wait_for_results();
    test_mixed_traffic(81, 200);
    wait_for_results();
    test_mixed_traffic(21, 200);
    wait_for_results();
    test_capacity_exhaustion();
    test_mixed_traffic(21, 125);

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
